[hdl/ucfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfr_pkg
// Shared types, frame constants and the reply microcode store.
// ----------------------------------------------------------------------------
package ucfr_pkg;

  localparam logic [7:0] SOF_BYTE = 8'hA5;
  localparam logic [7:0] EOF_BYTE = 8'h5A;
  localparam logic [7:0] ERR_BYTE = 8'hFF;

  localparam logic [7:0] TYPE_VER      = 8'h81;
  localparam logic [7:0] TYPE_UID      = 8'h82;
  localparam logic [7:0] TYPE_SET_BASE = 8'h84;
  localparam logic [7:0] TYPE_SET_LAST = 8'h88;
  localparam logic [7:0] TYPE_STATUS   = 8'h8A;
  localparam logic [7:0] TYPE_LOAD     = 8'h8B;

  localparam logic [15:0] LOAD_LEN  = 16'd7;
  localparam logic [63:0] UID_RESET = 64'h0102030405060708;

  // frame position counter only needs to tell bytes 0..8 apart, then saturates
  localparam logic [3:0] IDX_SAT     = 4'd9;
  localparam logic [3:0] IDX_PAY_LO  = 4'd4;
  localparam logic [3:0] IDX_PAY_HI  = 4'd8;

  typedef logic [4:0][7:0] byte5_t;

  typedef enum logic [2:0] {
    KIND_VER,
    KIND_UID,
    KIND_SET,
    KIND_STAT,
    KIND_ERR,
    KIND_ACK
  } reply_kind_t;

  typedef struct packed {
    logic        start;
    reply_kind_t kind;
    logic [7:0]  ftype;
  } reply_req_t;

  typedef enum logic [3:0] {
    SRC_SOF,
    SRC_LEN_HI,
    SRC_LEN_LO,
    SRC_TYPE,
    SRC_VER,
    SRC_UID,
    SRC_PAY,
    SRC_STAT,
    SRC_ZERO,
    SRC_ERR,
    SRC_XOR,
    SRC_EOF
  } src_t;

  typedef enum logic [1:0] {
    OP_NEXT,
    OP_DISPATCH,
    OP_JUMP,
    OP_END
  } op_t;

  typedef struct packed {
    src_t       src;
    logic [3:0] sel;
    op_t        op;
    logic [4:0] target;
  } cw_t;

  // program layout
  localparam logic [4:0] PC_HDR  = 5'd0;
  localparam logic [4:0] PC_VER  = 5'd4;
  localparam logic [4:0] PC_UID  = 5'd13;
  localparam logic [4:0] PC_SET  = 5'd21;
  localparam logic [4:0] PC_STAT = 5'd23;
  localparam logic [4:0] PC_ERR  = 5'd29;
  localparam logic [4:0] PC_TRL  = 5'd30;

  function automatic cw_t mk_cw(src_t src, logic [3:0] sel, op_t op, logic [4:0] target);
    cw_t cw;
    cw.src    = src;
    cw.sel    = sel;
    cw.op     = op;
    cw.target = target;
    return cw;
  endfunction

  function automatic cw_t ucode(logic [4:0] pc);
    cw_t cw;
    unique case (pc)
      5'd0:  cw = mk_cw(SRC_SOF,    4'd0, OP_NEXT,     PC_HDR);
      5'd1:  cw = mk_cw(SRC_LEN_HI, 4'd0, OP_NEXT,     PC_HDR);
      5'd2:  cw = mk_cw(SRC_LEN_LO, 4'd0, OP_NEXT,     PC_HDR);
      5'd3:  cw = mk_cw(SRC_TYPE,   4'd0, OP_DISPATCH, PC_HDR);
      5'd4:  cw = mk_cw(SRC_VER,    4'd0, OP_NEXT,     PC_HDR);
      5'd5:  cw = mk_cw(SRC_VER,    4'd1, OP_NEXT,     PC_HDR);
      5'd6:  cw = mk_cw(SRC_VER,    4'd2, OP_NEXT,     PC_HDR);
      5'd7:  cw = mk_cw(SRC_VER,    4'd3, OP_NEXT,     PC_HDR);
      5'd8:  cw = mk_cw(SRC_VER,    4'd4, OP_NEXT,     PC_HDR);
      5'd9:  cw = mk_cw(SRC_VER,    4'd5, OP_NEXT,     PC_HDR);
      5'd10: cw = mk_cw(SRC_VER,    4'd6, OP_NEXT,     PC_HDR);
      5'd11: cw = mk_cw(SRC_VER,    4'd7, OP_NEXT,     PC_HDR);
      5'd12: cw = mk_cw(SRC_VER,    4'd8, OP_JUMP,     PC_TRL);
      5'd13: cw = mk_cw(SRC_UID,    4'd0, OP_NEXT,     PC_HDR);
      5'd14: cw = mk_cw(SRC_UID,    4'd1, OP_NEXT,     PC_HDR);
      5'd15: cw = mk_cw(SRC_UID,    4'd2, OP_NEXT,     PC_HDR);
      5'd16: cw = mk_cw(SRC_UID,    4'd3, OP_NEXT,     PC_HDR);
      5'd17: cw = mk_cw(SRC_UID,    4'd4, OP_NEXT,     PC_HDR);
      5'd18: cw = mk_cw(SRC_UID,    4'd5, OP_NEXT,     PC_HDR);
      5'd19: cw = mk_cw(SRC_UID,    4'd6, OP_NEXT,     PC_HDR);
      5'd20: cw = mk_cw(SRC_UID,    4'd7, OP_JUMP,     PC_TRL);
      5'd21: cw = mk_cw(SRC_PAY,    4'd0, OP_NEXT,     PC_HDR);
      5'd22: cw = mk_cw(SRC_PAY,    4'd1, OP_JUMP,     PC_TRL);
      5'd23: cw = mk_cw(SRC_STAT,   4'd0, OP_NEXT,     PC_HDR);
      5'd24: cw = mk_cw(SRC_STAT,   4'd1, OP_NEXT,     PC_HDR);
      5'd25: cw = mk_cw(SRC_STAT,   4'd2, OP_NEXT,     PC_HDR);
      5'd26: cw = mk_cw(SRC_STAT,   4'd3, OP_NEXT,     PC_HDR);
      5'd27: cw = mk_cw(SRC_STAT,   4'd4, OP_NEXT,     PC_HDR);
      5'd28: cw = mk_cw(SRC_ZERO,   4'd0, OP_JUMP,     PC_TRL);
      5'd29: cw = mk_cw(SRC_ERR,    4'd0, OP_JUMP,     PC_TRL);
      5'd30: cw = mk_cw(SRC_XOR,    4'd0, OP_NEXT,     PC_HDR);
      5'd31: cw = mk_cw(SRC_EOF,    4'd0, OP_END,      PC_HDR);
      default: cw = mk_cw(SRC_EOF,  4'd0, OP_END,      PC_HDR);
    endcase
    return cw;
  endfunction

  // payload entry point and length low byte (payload count plus one)
  function automatic logic [4:0] kind_entry(reply_kind_t kind);
    logic [4:0] pc;
    unique case (kind)
      KIND_VER:  pc = PC_VER;
      KIND_UID:  pc = PC_UID;
      KIND_SET:  pc = PC_SET;
      KIND_STAT: pc = PC_STAT;
      KIND_ERR:  pc = PC_ERR;
      KIND_ACK:  pc = PC_TRL;
      default:   pc = PC_TRL;
    endcase
    return pc;
  endfunction

  function automatic logic [7:0] kind_len(reply_kind_t kind);
    logic [7:0] len;
    unique case (kind)
      KIND_VER:  len = 8'd10;
      KIND_UID:  len = 8'd9;
      KIND_SET:  len = 8'd3;
      KIND_STAT: len = 8'd7;
      KIND_ERR:  len = 8'd2;
      KIND_ACK:  len = 8'd1;
      default:   len = 8'd1;
    endcase
    return len;
  endfunction

  // version text "123456789"
  function automatic logic [7:0] ver_char(logic [3:0] sel);
    return 8'h31 + {4'd0, sel};
  endfunction

  function automatic logic [7:0] set_limit(logic [2:0] s);
    logic [7:0] lim;
    unique case (s)
      3'd0:    lim = 8'd1;
      3'd1:    lim = 8'd14;
      3'd2:    lim = 8'd6;
      3'd3:    lim = 8'd2;
      3'd4:    lim = 8'd1;
      default: lim = 8'd0;
    endcase
    return lim;
  endfunction

endpackage
`default_nettype wire

[hdl/ucfr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfr_if
// Valid/ready channel interfaces for received bytes and reply bytes.
// ----------------------------------------------------------------------------
interface ucfr_in_if;
  logic       valid;
  logic       ready;
  logic       port;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, port, data_byte, frame_end, input ready);
  modport sink   (input valid, port, data_byte, frame_end, output ready);
endinterface

interface ucfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_last;

  modport source (output valid, reply_byte, reply_last, input ready);
  modport sink   (input valid, reply_byte, reply_last, output ready);
endinterface
`default_nettype wire

[hdl/ucfr_rx_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfr_rx_parser
// Frame capture and check; holds status bytes and issues reply requests.
// ----------------------------------------------------------------------------
module ucfr_rx_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic                port,
  input  wire logic [7:0]          data_byte,
  input  wire logic                frame_end,
  output ucfr_pkg::reply_req_t     req,
  output ucfr_pkg::byte5_t         payload,
  output ucfr_pkg::byte5_t         status
);
  import ucfr_pkg::*;

  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        start_ok_r, start_ok_nxt;
  logic        port_r, port_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  byte5_t      pay_r, pay_nxt;
  byte5_t      stat_r, stat_nxt;
  logic [3:0]  pay_off;
  logic [7:0]  set_diff;
  logic [2:0]  set_sel;
  logic        good;

  assign pay_off  = idx_r - IDX_PAY_LO;
  assign set_diff = type_nxt - TYPE_SET_BASE;
  assign set_sel  = set_diff[2:0];

  always_comb begin
    idx_nxt      = idx_r;
    xor_nxt      = xor_r;
    start_ok_nxt = start_ok_r;
    port_nxt     = port_r;
    len_nxt      = len_r;
    type_nxt     = type_r;
    pay_nxt      = pay_r;
    stat_nxt     = stat_r;
    good         = 1'b0;
    req          = '0;
    req.kind     = KIND_ERR;
    if (accept) begin
      if (idx_r == 4'd0) begin
        port_nxt     = port;
        start_ok_nxt = (data_byte == SOF_BYTE);
        pay_nxt      = '0;
        len_nxt      = '0;
        type_nxt     = '0;
      end else if (idx_r == 4'd1) begin
        len_nxt[15:8] = data_byte;
      end else if (idx_r == 4'd2) begin
        len_nxt[7:0] = data_byte;
      end else if (idx_r == 4'd3) begin
        type_nxt = data_byte;
      end else if (idx_r <= IDX_PAY_HI) begin
        pay_nxt[pay_off[2:0]] = data_byte;
      end

      if (!frame_end) begin
        xor_nxt = ((idx_r == 4'd0) ? 8'd0 : xor_r) ^ data_byte;
        if (idx_r != IDX_SAT) begin
          idx_nxt = idx_r + 4'd1;
        end
      end else begin
        idx_nxt   = '0;
        xor_nxt   = '0;
        good      = start_ok_r && (data_byte == EOF_BYTE) && (idx_r >= IDX_PAY_LO);
        req.ftype = type_nxt;
        if (good) begin
          // xor over everything up to and including the checksum must be zero
          if (xor_r != 8'd0) begin
            req.start = 1'b1;
            req.kind  = KIND_ERR;
          end else if (!port_r) begin
            case (type_nxt) inside
              TYPE_VER: begin
                req.start = 1'b1;
                req.kind  = KIND_VER;
              end
              TYPE_UID: begin
                req.start = 1'b1;
                req.kind  = KIND_UID;
              end
              [TYPE_SET_BASE:TYPE_SET_LAST]: begin
                req.start = 1'b1;
                if (pay_nxt[0] <= set_limit(set_sel)) begin
                  stat_nxt[set_sel] = pay_nxt[0];
                  req.kind          = KIND_SET;
                end else begin
                  req.kind = KIND_ERR;
                end
              end
              TYPE_STATUS: begin
                req.start = 1'b1;
                req.kind  = KIND_STAT;
              end
              default: begin
                req.start = 1'b0;
              end
            endcase
          end else if ((type_nxt == TYPE_STATUS || type_nxt == TYPE_LOAD)
                       && len_nxt == LOAD_LEN) begin
            stat_nxt  = pay_nxt;
            req.start = 1'b1;
            req.kind  = KIND_ACK;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      xor_r      <= '0;
      start_ok_r <= 1'b0;
      port_r     <= 1'b0;
      len_r      <= '0;
      type_r     <= '0;
      pay_r      <= '0;
      stat_r     <= '0;
    end else begin
      idx_r      <= idx_nxt;
      xor_r      <= xor_nxt;
      start_ok_r <= start_ok_nxt;
      port_r     <= port_nxt;
      len_r      <= len_nxt;
      type_r     <= type_nxt;
      pay_r      <= pay_nxt;
      stat_r     <= stat_nxt;
    end
  end

  assign payload = pay_r;
  assign status  = stat_r;

endmodule
`default_nettype wire

[hdl/ucfr_reply_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfr_reply_seq
// Microcoded reply sequencer: step counter, control store, byte datapath.
// ----------------------------------------------------------------------------
module ucfr_reply_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  ucfr_pkg::reply_req_t     req,
  input  ucfr_pkg::byte5_t         payload,
  input  ucfr_pkg::byte5_t         status,
  input  wire logic [63:0]         uid,
  output logic                     busy,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     out_last
);
  import ucfr_pkg::*;

  logic        busy_r, busy_nxt;
  logic [4:0]  pc_r, pc_nxt;
  reply_kind_t kind_r, kind_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  cw_t         cw;
  logic        step;
  logic [7:0]  sel_byte;
  logic [5:0]  uid_lsb;

  assign cw      = ucode(pc_r);
  assign step    = busy_r && (!valid_r || out_ready);
  assign uid_lsb = {3'd7 - cw.sel[2:0], 3'd0};

  always_comb begin
    case (cw.src)
      SRC_SOF:    sel_byte = SOF_BYTE;
      SRC_LEN_HI: sel_byte = 8'd0;
      SRC_LEN_LO: sel_byte = kind_len(kind_r);
      SRC_TYPE:   sel_byte = type_r;
      SRC_VER:    sel_byte = ver_char(cw.sel);
      SRC_UID:    sel_byte = uid[uid_lsb +: 8];
      SRC_PAY:    sel_byte = payload[cw.sel[2:0]];
      SRC_STAT:   sel_byte = status[cw.sel[2:0]];
      SRC_ZERO:   sel_byte = 8'd0;
      SRC_ERR:    sel_byte = ERR_BYTE;
      SRC_XOR:    sel_byte = xor_r;
      SRC_EOF:    sel_byte = EOF_BYTE;
      default:    sel_byte = 8'd0;
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    pc_nxt    = pc_r;
    kind_nxt  = kind_r;
    type_nxt  = type_r;
    xor_nxt   = xor_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (req.start) begin
      busy_nxt = 1'b1;
      pc_nxt   = PC_HDR;
      kind_nxt = req.kind;
      type_nxt = req.ftype;
      xor_nxt  = '0;
    end else if (step) begin
      valid_nxt = 1'b1;
      byte_nxt  = sel_byte;
      last_nxt  = (cw.op == OP_END);
      if (cw.src != SRC_XOR && cw.src != SRC_EOF) begin
        xor_nxt = xor_r ^ sel_byte;
      end
      unique case (cw.op)
        OP_NEXT:     pc_nxt = pc_r + 5'd1;
        OP_DISPATCH: pc_nxt = kind_entry(kind_r);
        OP_JUMP:     pc_nxt = cw.target;
        OP_END:      busy_nxt = 1'b0;
        default:     busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pc_r    <= PC_HDR;
      kind_r  <= KIND_ERR;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      pc_r    <= pc_nxt;
      kind_r  <= kind_nxt;
      valid_r <= valid_nxt;
    end
    type_r <= type_nxt;
    xor_r  <= xor_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

[hdl/uart_command_frame_responder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_command_frame_responder
// Checks received command frames and plays out framed replies byte by byte.
// ----------------------------------------------------------------------------
//  channel   dir  transfer payload                  handshake
//  in_chan   in   port, data_byte, frame_end       valid/ready
//  out_chan  out  reply_byte, reply_last           valid/ready
//  cfg_*     in   device id, 64 bits               write enable only
//
//  A frame end that needs a reply starts the sequencer; it emits one reply
//  byte per cycle while out_chan is ready (6 to 15 bytes) and holds
//  in_chan.ready low meanwhile. A stall on out_chan holds the sequencer in
//  place. Reset is synchronous and clears all control and stored status;
//  the device id returns to its reset value.
// ----------------------------------------------------------------------------
module uart_command_frame_responder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ucfr_in_if.sink          in_chan,
  ucfr_out_if.source       out_chan,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata
);
  import ucfr_pkg::*;

  logic [63:0] uid_r, uid_nxt;
  reply_req_t  req;
  byte5_t      payload;
  byte5_t      status;
  logic        busy;
  logic        accept;

  assign uid_nxt        = cfg_we ? cfg_wdata : uid_r;
  assign in_chan.ready  = !busy;
  assign accept         = in_chan.valid && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uid_r <= UID_RESET;
    end else begin
      uid_r <= uid_nxt;
    end
  end

  ucfr_rx_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .port      (in_chan.port),
    .data_byte (in_chan.data_byte),
    .frame_end (in_chan.frame_end),
    .req       (req),
    .payload   (payload),
    .status    (status)
  );

  ucfr_reply_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .payload   (payload),
    .status    (status),
    .uid       (uid_r),
    .busy      (busy),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_byte  (out_chan.reply_byte),
    .out_last  (out_chan.reply_last)
  );

endmodule
`default_nettype wire
